// ----- rtl/core/rau_pkg.sv -----
`default_nettype none
// ----------------------------------------------------------------------------
// rau_pkg: shared types and constants of the rational arithmetic unit
// Operation codes, status codes and the descriptor passed front to back.
// ----------------------------------------------------------------------------
package rau_pkg;

    localparam int unsigned RAU_WIDTH = 32;
    localparam int unsigned MAG_W     = 64;   // exact product magnitude

    localparam logic [2:0] MODE_ADD   = 3'd0;
    localparam logic [2:0] MODE_SUB   = 3'd1;
    localparam logic [2:0] MODE_MUL   = 3'd2;
    localparam logic [2:0] MODE_DIV   = 3'd3;
    localparam logic [2:0] MODE_NORM  = 3'd4;
    localparam logic [2:0] MODE_EQ    = 3'd5;

    localparam logic [1:0] ST_OK      = 2'd0;
    localparam logic [1:0] ST_ZERO    = 2'd1;
    localparam logic [1:0] ST_OVF     = 2'd2;

    // classified job handed from the front to the back
    typedef struct packed {
        logic              err;    // zero denominator or bad mode
        logic              eq;     // equality test: two reductions
        logic              nneg;
        logic [MAG_W-1:0]  nmag;
        logic              dneg;
        logic [MAG_W-1:0]  dmag;
        logic              n2neg;  // second fraction for equality test
        logic [MAG_W-1:0]  n2mag;
        logic              d2neg;
        logic [MAG_W-1:0]  d2mag;
    } rau_job_t;

endpackage : rau_pkg
`default_nettype wire

// ----- rtl/core/rational_arithmetic_unit.sv -----
`default_nettype none
// ----------------------------------------------------------------------------
// rational_arithmetic_unit: fraction add/sub/mul/div/normalize/compare
// Exact double-width cross products, gcd reduction, sign on the numerator.
// ----------------------------------------------------------------------------
// Usage:
//   Input channel (in_valid/in_ready) transfers mode and the two fractions
//   a_num/a_den, b_num/b_den. Output channel (out_valid/out_ready) transfers
//   res_num, res_den, is_equal and status, one result per input.
//   The front works on one item at a time (capture, products, sum, hand-off)
//   and passes a job through a two-entry queue to the back engine.
//   The back runs a binary gcd on 64-bit magnitudes and two restoring
//   divisions for each item; equality mode does this for both fractions.
//   The back engine sets the throughput; the front may run ahead by up to
//   two queued jobs.
//   Errors (zero denominator, bad mode) bypass the gcd and the divisions.
//   Reset clears all control state; no item is pending afterwards.
//   A stalled receiver holds the result; the queue then fills and
//   in_ready drops.
// ----------------------------------------------------------------------------
module rational_arithmetic_unit
    import rau_pkg::*;
#(
    parameter int unsigned WIDTH = RAU_WIDTH
)
(
    input  wire logic         clk,
    input  wire logic         rst_n,
    input  wire logic         in_valid,
    output logic              in_ready,
    input  wire logic [2:0]   mode,
    input  wire logic [31:0]  a_num,
    input  wire logic [31:0]  a_den,
    input  wire logic [31:0]  b_num,
    input  wire logic [31:0]  b_den,
    output logic              out_valid,
    input  wire logic         out_ready,
    output logic [31:0]       res_num,
    output logic [30:0]       res_den,
    output logic              is_equal,
    output logic [1:0]        status
);

    rau_job_t f_job, b_job;
    logic     f_valid, f_ready, b_valid, b_ready;

    rau_front #(.WIDTH(WIDTH)) u_front (
        .clk(clk), .rst_n(rst_n),
        .in_valid(in_valid), .in_ready(in_ready),
        .mode(mode), .a_num(a_num), .a_den(a_den), .b_num(b_num), .b_den(b_den),
        .job_valid(f_valid), .job_ready(f_ready), .job(f_job)
    );

    rau_queue u_queue (
        .clk(clk), .rst_n(rst_n),
        .wr_valid(f_valid), .wr_ready(f_ready), .wr_job(f_job),
        .rd_valid(b_valid), .rd_ready(b_ready), .rd_job(b_job)
    );

    rau_back #(.WIDTH(WIDTH)) u_back (
        .clk(clk), .rst_n(rst_n),
        .job_valid(b_valid), .job_ready(b_ready), .job(b_job),
        .out_valid(out_valid), .out_ready(out_ready),
        .res_num(res_num), .res_den(res_den), .is_equal(is_equal), .status(status)
    );

endmodule : rational_arithmetic_unit
`default_nettype wire

// ----- rtl/core/rau_front.sv -----
`default_nettype none
// ----------------------------------------------------------------------------
// rau_front: operand split and cross products
// Sign/magnitude split, three 32x32 products in a second step, job build.
// ----------------------------------------------------------------------------
module rau_front
    import rau_pkg::*;
#(
    parameter int unsigned WIDTH = RAU_WIDTH
)
(
    input  wire logic              clk,
    input  wire logic              rst_n,
    input  wire logic              in_valid,
    output logic                   in_ready,
    input  wire logic [2:0]        mode,
    input  wire logic [31:0]       a_num,
    input  wire logic [31:0]       a_den,
    input  wire logic [31:0]       b_num,
    input  wire logic [31:0]       b_den,
    output logic                   job_valid,
    input  wire logic              job_ready,
    output rau_job_t               job
);

    typedef enum logic [2:0] {
        F_IDLE = 3'b001,
        F_MUL  = 3'b010,
        F_ADD  = 3'b100
    } fstate_t;

    fstate_t          state_reg, state_next;
    logic [2:0]       mode_reg;
    logic             s_reg [4];
    logic [WIDTH-1:0] m_reg [4];
    logic [MAG_W-1:0] p_reg, q_reg, r_reg;
    logic             out_valid_reg;
    rau_job_t         job_reg, job_next;

    logic [31:0]      raw [4];
    logic             sx [4];
    logic [WIDTH-1:0] mx [4];

    assign raw[0] = a_num;
    assign raw[1] = a_den;
    assign raw[2] = b_num;
    assign raw[3] = b_den;

    // sign/magnitude of the low WIDTH bits
    always_comb
    begin
        for (int i = 0; i < 4; i++)
        begin
            sx[i] = raw[i][WIDTH-1];
            mx[i] = sx[i] ? (~raw[i][WIDTH-1:0] + 1'b1) : raw[i][WIDTH-1:0];
        end
    end

    assign in_ready  = (state_reg == F_IDLE) && !out_valid_reg;
    assign job_valid = out_valid_reg;
    assign job       = job_reg;

    // product operands per mode: p = x0*y0, q = x1*y1, r = x2*y2
    logic [WIDTH-1:0] x0, y0, x1, y1, x2, y2;
    always_comb
    begin
        x0 = m_reg[0]; y0 = m_reg[3];
        x1 = m_reg[2]; y1 = m_reg[1];
        x2 = m_reg[1]; y2 = m_reg[3];
        unique case (mode_reg)
            MODE_MUL:
            begin
                x0 = m_reg[0]; y0 = m_reg[2];
            end
            MODE_DIV:
            begin
                x2 = m_reg[1]; y2 = m_reg[2];
            end
            default: ;
        endcase
    end

    // job assembly
    logic             ps, qs, ss;
    logic [MAG_W-1:0] sm;
    logic             zero_err;
    always_comb
    begin
        job_next = '0;
        ps = s_reg[0] ^ s_reg[3];
        qs = s_reg[2] ^ s_reg[1] ^ (mode_reg == MODE_SUB);
        if (ps == qs)
        begin
            ss = ps; sm = p_reg + q_reg;
        end
        else if (p_reg >= q_reg)
        begin
            ss = ps; sm = p_reg - q_reg;
        end
        else
        begin
            ss = qs; sm = q_reg - p_reg;
        end
        zero_err = (m_reg[1] == '0) ||
                   ((mode_reg != MODE_NORM) && (m_reg[3] == '0)) ||
                   ((mode_reg == MODE_DIV) && (m_reg[2] == '0));
        job_next.err = zero_err;
        unique case (mode_reg)
            MODE_ADD, MODE_SUB:
            begin
                job_next.nneg = ss;              job_next.nmag = sm;
                job_next.dneg = s_reg[1] ^ s_reg[3]; job_next.dmag = r_reg;
            end
            MODE_MUL:
            begin
                job_next.nneg = s_reg[0] ^ s_reg[2]; job_next.nmag = p_reg;
                job_next.dneg = s_reg[1] ^ s_reg[3]; job_next.dmag = r_reg;
            end
            MODE_DIV:
            begin
                job_next.nneg = s_reg[0] ^ s_reg[3]; job_next.nmag = p_reg;
                job_next.dneg = s_reg[1] ^ s_reg[2]; job_next.dmag = r_reg;
            end
            MODE_NORM:
            begin
                job_next.nneg = s_reg[0]; job_next.nmag = MAG_W'(m_reg[0]);
                job_next.dneg = s_reg[1]; job_next.dmag = MAG_W'(m_reg[1]);
            end
            MODE_EQ:
            begin
                job_next.eq    = 1'b1;
                job_next.nneg  = s_reg[0]; job_next.nmag  = MAG_W'(m_reg[0]);
                job_next.dneg  = s_reg[1]; job_next.dmag  = MAG_W'(m_reg[1]);
                job_next.n2neg = s_reg[2]; job_next.n2mag = MAG_W'(m_reg[2]);
                job_next.d2neg = s_reg[3]; job_next.d2mag = MAG_W'(m_reg[3]);
            end
            default:
                job_next.err = 1'b1;
        endcase
    end

    // control sequence
    always_comb
    begin
        state_next = state_reg;
        unique case (state_reg)
            F_IDLE: if (in_valid && in_ready) state_next = F_MUL;
            F_MUL:  state_next = F_ADD;
            F_ADD:  state_next = F_IDLE;
            default: state_next = F_IDLE;
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= F_IDLE;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg <= state_next;
            if (state_reg == F_ADD)
                out_valid_reg <= 1'b1;
            else if (job_ready)
                out_valid_reg <= 1'b0;
        end
    end

    // datapath registers
    always_ff @(posedge clk)
    begin
        if (state_reg == F_IDLE && in_valid && in_ready)
        begin
            mode_reg <= mode;
            for (int i = 0; i < 4; i++)
            begin
                s_reg[i] <= sx[i];
                m_reg[i] <= mx[i];
            end
        end
        if (state_reg == F_MUL)
        begin
            p_reg <= MAG_W'(x0 * y0);
            q_reg <= MAG_W'(x1 * y1);
            r_reg <= MAG_W'(x2 * y2);
        end
        if (state_reg == F_ADD)
            job_reg <= job_next;
    end

endmodule : rau_front
`default_nettype wire

// ----- rtl/core/rau_queue.sv -----
`default_nettype none
// ----------------------------------------------------------------------------
// rau_queue: two-entry job queue
// Decouples the front from the back; registered outputs both ways.
// ----------------------------------------------------------------------------
module rau_queue
    import rau_pkg::*;
(
    input  wire logic  clk,
    input  wire logic  rst_n,
    input  wire logic  wr_valid,
    output logic       wr_ready,
    input  rau_job_t   wr_job,
    output logic       rd_valid,
    input  wire logic  rd_ready,
    output rau_job_t   rd_job
);

    rau_job_t   mem_reg [2];
    logic       wp_reg, rp_reg;
    logic [1:0] cnt_reg;

    assign wr_ready = (cnt_reg != 2'd2);
    assign rd_valid = (cnt_reg != 2'd0);
    assign rd_job   = mem_reg[rp_reg];

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wp_reg  <= 1'b0;
            rp_reg  <= 1'b0;
            cnt_reg <= 2'd0;
        end
        else
        begin
            if (wr_valid && wr_ready) wp_reg <= ~wp_reg;
            if (rd_valid && rd_ready) rp_reg <= ~rp_reg;
            cnt_reg <= cnt_reg + 2'(wr_valid && wr_ready) - 2'(rd_valid && rd_ready);
        end
    end

    always_ff @(posedge clk)
    begin
        if (wr_valid && wr_ready)
            mem_reg[wp_reg] <= wr_job;
    end

endmodule : rau_queue
`default_nettype wire

// ----- rtl/core/rau_back.sv -----
`default_nettype none
// ----------------------------------------------------------------------------
// rau_back: reduction engine
// Binary gcd, two restoring divisions, range check and result register.
// ----------------------------------------------------------------------------
module rau_back
    import rau_pkg::*;
#(
    parameter int unsigned WIDTH = RAU_WIDTH
)
(
    input  wire logic         clk,
    input  wire logic         rst_n,
    input  wire logic         job_valid,
    output logic              job_ready,
    input  rau_job_t          job,
    output logic              out_valid,
    input  wire logic         out_ready,
    output logic [31:0]       res_num,
    output logic [30:0]       res_den,
    output logic              is_equal,
    output logic [1:0]        status
);

    localparam int unsigned SH_W = $clog2(MAG_W) + 1;
    localparam int unsigned DC_W = $clog2(MAG_W);

    typedef enum logic [7:0] {
        B_IDLE  = 8'b0000_0001,
        B_GCD   = 8'b0000_0010,
        B_DIVN  = 8'b0000_0100,
        B_DIVD  = 8'b0000_1000,
        B_NEXT  = 8'b0001_0000,
        B_CHECK = 8'b0010_0000,
        B_LOAD  = 8'b0100_0000,
        B_OUT   = 8'b1000_0000
    } bstate_t;

    bstate_t          state_reg, state_next;
    rau_job_t         job_reg;
    logic             second_reg;     // working on the second fraction
    logic             neg_reg;
    logic [MAG_W-1:0] n_reg, d_reg;   // current fraction
    logic [MAG_W-1:0] u_reg, v_reg;   // gcd operands
    logic [SH_W-1:0]  k_reg;          // common power of two
    logic [MAG_W-1:0] g_reg;
    logic [MAG_W-1:0] q_reg, r_reg, dvd_reg;
    logic [DC_W-1:0]  cnt_reg;
    logic [MAG_W-1:0] rn_reg, rd_reg; // reduced numerator, denominator
    logic             x_neg_reg;
    logic [MAG_W-1:0] x_n_reg, x_d_reg;
    logic [31:0]      res_num_reg;
    logic [30:0]      res_den_reg;
    logic             eq_reg;
    logic [1:0]       status_reg;

    assign job_ready = (state_reg == B_IDLE);
    assign out_valid = (state_reg == B_OUT);
    assign res_num   = res_num_reg;
    assign res_den   = res_den_reg;
    assign is_equal  = eq_reg;
    assign status    = status_reg;

    // one restoring-division step on the current divisor g_reg
    logic [MAG_W:0]   rem_sh;
    logic             q_bit;
    always_comb
    begin
        rem_sh = {r_reg, dvd_reg[MAG_W-1]};
        q_bit  = (rem_sh >= {1'b0, g_reg});
    end

    logic [MAG_W-1:0] uv_diff;
    assign uv_diff = (u_reg > v_reg) ? (u_reg - v_reg) : (v_reg - u_reg);

    // range check of the reduced result
    localparam logic [MAG_W-1:0] HALF = MAG_W'(1) << (WIDTH - 1);
    logic ovf;
    assign ovf = (rn_reg > (neg_reg ? HALF : HALF - 1'b1)) || (rd_reg > HALF - 1'b1);

    logic [MAG_W-1:0] sn;
    assign sn = neg_reg ? (~rn_reg + 1'b1) : rn_reg;

    always_comb
    begin
        state_next = state_reg;
        unique case (state_reg)
            B_IDLE:  if (job_valid) state_next = B_LOAD;
            B_LOAD:
            begin
                if (job_reg.err)        state_next = B_CHECK;
                else if (n_reg == '0)   state_next = B_NEXT;
                else                    state_next = B_GCD;
            end
            B_GCD:   if (u_reg == v_reg) state_next = B_DIVN;
            B_DIVN:  if (cnt_reg == '1) state_next = B_DIVD;
            B_DIVD:  if (cnt_reg == '1) state_next = B_NEXT;
            B_NEXT:  state_next = (job_reg.eq && !second_reg) ? B_LOAD : B_CHECK;
            B_CHECK: state_next = B_OUT;
            B_OUT:   if (out_ready) state_next = B_IDLE;
            default: state_next = B_IDLE;
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            state_reg <= B_IDLE;
        else
            state_reg <= state_next;
    end

    always_ff @(posedge clk)
    begin
        unique case (state_reg)
            B_IDLE:
            begin
                job_reg    <= job;
                second_reg <= 1'b0;
                neg_reg    <= job.nneg ^ job.dneg;
                n_reg      <= job.nmag;
                d_reg      <= job.dmag;
            end
            B_LOAD:
            begin
                u_reg <= n_reg;
                v_reg <= d_reg;
                k_reg <= '0;
                if (n_reg == '0)
                begin
                    rn_reg  <= '0;
                    rd_reg  <= MAG_W'(1);
                    neg_reg <= 1'b0;
                end
            end
            B_GCD:
            begin
                // binary gcd: strip common twos, then subtract
                if (u_reg == v_reg)
                begin
                    g_reg   <= u_reg << k_reg;
                    cnt_reg <= '0;
                    r_reg   <= '0;
                    dvd_reg <= n_reg;
                end
                else if (!u_reg[0] && !v_reg[0])
                begin
                    u_reg <= u_reg >> 1;
                    v_reg <= v_reg >> 1;
                    k_reg <= k_reg + 1'b1;
                end
                else if (!u_reg[0])
                    u_reg <= u_reg >> 1;
                else if (!v_reg[0])
                    v_reg <= v_reg >> 1;
                else
                begin
                    u_reg <= (u_reg > v_reg) ? uv_diff : u_reg;
                    v_reg <= (u_reg > v_reg) ? v_reg : uv_diff;
                end
            end
            B_DIVN, B_DIVD:
            begin
                q_reg   <= {q_reg[MAG_W-2:0], q_bit};
                cnt_reg <= cnt_reg + 1'b1;
                if (cnt_reg == '1)
                begin
                    // last step: prime the second division
                    r_reg   <= '0;
                    dvd_reg <= d_reg;
                    if (state_reg == B_DIVN)
                        rn_reg <= {q_reg[MAG_W-2:0], q_bit};
                    else
                        rd_reg <= {q_reg[MAG_W-2:0], q_bit};
                end
                else
                begin
                    r_reg   <= q_bit ? MAG_W'(rem_sh - {1'b0, g_reg}) : rem_sh[MAG_W-1:0];
                    dvd_reg <= dvd_reg << 1;
                end
            end
            B_NEXT:
            begin
                // equality mode, first pass: keep the first reduced fraction, load the second
                second_reg <= 1'b1;
                if (job_reg.eq && !second_reg)
                begin
                    x_neg_reg <= neg_reg;
                    x_n_reg   <= rn_reg;
                    x_d_reg   <= rd_reg;
                    neg_reg   <= job_reg.n2neg ^ job_reg.d2neg;
                    n_reg     <= job_reg.n2mag;
                    d_reg     <= job_reg.d2mag;
                end
            end
            B_CHECK:
            begin
                if (job_reg.err)
                begin
                    status_reg  <= ST_ZERO;
                    res_num_reg <= '0;
                    res_den_reg <= '0;
                    eq_reg      <= 1'b0;
                end
                else if (job_reg.eq)
                begin
                    status_reg  <= ST_OK;
                    res_num_reg <= '0;
                    res_den_reg <= '0;
                    eq_reg      <= (x_neg_reg == neg_reg) && (x_n_reg == rn_reg) &&
                                   (x_d_reg == rd_reg);
                end
                else if (ovf)
                begin
                    status_reg  <= ST_OVF;
                    res_num_reg <= '0;
                    res_den_reg <= '0;
                    eq_reg      <= 1'b0;
                end
                else
                begin
                    status_reg  <= ST_OK;
                    res_num_reg <= 32'(signed'(sn[WIDTH-1:0]));
                    res_den_reg <= 31'(rd_reg[WIDTH-1:0]);
                    eq_reg      <= 1'b0;
                end
            end
            default: ;
        endcase
    end

endmodule : rau_back
`default_nettype wire

// ----- sim/rational_arithmetic_unit_tb.sv -----
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// rational_arithmetic_unit_tb: self-checking regression of the fraction unit
// A directed table of corner cases is followed by random fraction pairs.
// Each transfer is predicted in the bench or taken from the table, compared
// field by field. Both channels idle in random bursts but not at the end.
// ----------------------------------------------------------------------------
module rational_arithmetic_unit_tb;
    import rau_pkg::*;

    localparam logic [2:0] MODE_BAD6 = 3'd6;
    localparam logic [2:0] MODE_BAD7 = 3'd7;
    localparam int N_RANDOM = 1330;
    localparam int N_CALM   = 150;    // final stretch with no idling
    localparam int N_DIR    = 24;

    typedef struct packed {
        logic [31:0] num;
        logic [30:0] den;
        logic        eq;
        logic [1:0]  st;
    } frac_result_t;

    typedef struct packed {
        logic        neg;
        logic [63:0] n;
        logic [63:0] d;
    } reduced_t;

    typedef struct packed {
        logic [2:0]   md;
        logic [31:0]  an;
        logic [31:0]  ad;
        logic [31:0]  bn;
        logic [31:0]  bd;
        logic         chk;    // expected value typed in below
        frac_result_t want;
    } stim_row_t;

    logic         clk;
    logic         rst_n;
    logic         in_valid;
    logic         in_ready;
    logic [2:0]   mode;
    logic [31:0]  a_num, a_den, b_num, b_den;
    logic         out_valid;
    logic         out_ready;
    logic [31:0]  res_num;
    logic [30:0]  res_den;
    logic         is_equal;
    logic [1:0]   status;

    frac_result_t expected_q[$];
    logic         row_chk;
    frac_result_t row_want;
    bit           calm;
    int           n_errors;
    int           n_results;
    int           n_sent;

    // directed corner cases
    stim_row_t dir_rows [N_DIR] = '{
        '{MODE_ADD,  32'd1, 32'd2, 32'd1, 32'd3, 1'b0, '0},
        '{MODE_SUB,  32'd1, 32'd2, 32'd1, 32'd3, 1'b0, '0},
        '{MODE_MUL,  32'd2, 32'd3, 32'd3, 32'd4, 1'b0, '0},
        '{MODE_DIV,  32'd1, 32'd2, 32'd3, 32'd4, 1'b0, '0},
        '{MODE_NORM, 32'd6, -32'sd4, 32'd0, 32'd0, 1'b1, '{-32'sd3, 31'd2, 1'b0, ST_OK}},
        '{MODE_EQ,   32'd1, 32'd2, 32'd2, 32'd4, 1'b1, '{32'd0, 31'd0, 1'b1, ST_OK}},
        '{MODE_EQ,   32'd1, 32'd2, -32'sd1, 32'd2, 1'b1, '{32'd0, 31'd0, 1'b0, ST_OK}},
        '{MODE_ADD,  32'd5, 32'd0, 32'd1, 32'd3, 1'b1, '{32'd0, 31'd0, 1'b0, ST_ZERO}},
        '{MODE_MUL,  32'd5, 32'd7, 32'd1, 32'd0, 1'b1, '{32'd0, 31'd0, 1'b0, ST_ZERO}},
        '{MODE_DIV,  32'd5, 32'd7, 32'd0, 32'd3, 1'b1, '{32'd0, 31'd0, 1'b0, ST_ZERO}},
        '{MODE_NORM, 32'd5, 32'd0, 32'd1, 32'd1, 1'b1, '{32'd0, 31'd0, 1'b0, ST_ZERO}},
        '{MODE_EQ,   32'd1, 32'd1, 32'd1, 32'd0, 1'b1, '{32'd0, 31'd0, 1'b0, ST_ZERO}},
        '{MODE_BAD6, 32'd1, 32'd1, 32'd1, 32'd1, 1'b1, '{32'd0, 31'd0, 1'b0, ST_ZERO}},
        '{MODE_BAD7, 32'd1, 32'd1, 32'd1, 32'd1, 1'b1, '{32'd0, 31'd0, 1'b0, ST_ZERO}},
        '{MODE_NORM, 32'd0, -32'sd7, 32'd0, 32'd0, 1'b1, '{32'd0, 31'd1, 1'b0, ST_OK}},
        '{MODE_NORM, 32'h8000_0000, 32'd1, 32'd0, 32'd0, 1'b1,
          '{32'h8000_0000, 31'd1, 1'b0, ST_OK}},
        '{MODE_NORM, 32'h7FFF_FFFF, 32'd1, 32'd0, 32'd0, 1'b1,
          '{32'h7FFF_FFFF, 31'd1, 1'b0, ST_OK}},
        '{MODE_NORM, 32'd1, 32'h8000_0000, 32'd0, 32'd0, 1'b1, '{32'd0, 31'd0, 1'b0, ST_OVF}},
        '{MODE_NORM, 32'h8000_0000, -32'sd1, 32'd0, 32'd0, 1'b1,
          '{32'd0, 31'd0, 1'b0, ST_OVF}},
        '{MODE_MUL,  32'h7FFF_FFFF, 32'd1, 32'h7FFF_FFFF, 32'd1, 1'b1,
          '{32'd0, 31'd0, 1'b0, ST_OVF}},
        '{MODE_ADD,  32'h8000_0000, 32'd1, 32'h8000_0000, 32'd1, 1'b0, '0},
        '{MODE_DIV,  32'h8000_0000, 32'h7FFF_FFFF, 32'h8000_0000, 32'h7FFF_FFFF, 1'b0, '0},
        '{MODE_SUB,  32'hFFFF_FFFF, 32'hFFFF_FFFF, 32'h7FFF_FFFF, 32'h8000_0000, 1'b0, '0},
        '{MODE_EQ,   32'h8000_0000, 32'h8000_0000, 32'd1, 32'd1, 1'b1,
          '{32'd0, 31'd0, 1'b1, ST_OK}}
    };

    rational_arithmetic_unit u_dut (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (in_valid),
        .in_ready  (in_ready),
        .mode      (mode),
        .a_num     (a_num),
        .a_den     (a_den),
        .b_num     (b_num),
        .b_den     (b_den),
        .out_valid (out_valid),
        .out_ready (out_ready),
        .res_num   (res_num),
        .res_den   (res_den),
        .is_equal  (is_equal),
        .status    (status)
    );

    always
    begin
        clk = 1'b1;
        #5;
        clk = 1'b0;
        #5;
    end

    // two's complement word to magnitude
    function automatic logic [63:0] magnitude(input logic [31:0] v);
        logic [31:0] m;
        begin
            m = v[31] ? (~v + 32'd1) : v;
            return {32'd0, m};
        end
    endfunction

    function automatic logic [63:0] gcd_of(input logic [63:0] x, input logic [63:0] y);
        logic [63:0] t;
        begin
            while (y != 64'd0)
            begin
                t = x % y;
                x = y;
                y = t;
            end
            return x;
        end
    endfunction

    // dm must be nonzero
    function automatic reduced_t reduce_frac(input logic nn, input logic [63:0] nm,
                                             input logic dn, input logic [63:0] dm);
        reduced_t r;
        logic [63:0] g;
        begin
            if (nm == 64'd0)
            begin
                r.neg = 1'b0;
                r.n   = 64'd0;
                r.d   = 64'd1;
            end
            else
            begin
                g     = gcd_of(nm, dm);
                r.neg = nn ^ dn;
                r.n   = nm / g;
                r.d   = dm / g;
            end
            return r;
        end
    endfunction

    // expected result of one fraction operation
    function automatic frac_result_t predict_fraction(input logic [2:0] md,
        input logic [31:0] an_w, input logic [31:0] ad_w,
        input logic [31:0] bn_w, input logic [31:0] bd_w);
        frac_result_t o;
        reduced_t     r, x, y;
        logic [63:0]  an, ad, bn, bd, p, q, m;
        logic         ps, qs, s, err;
        logic [63:0]  nlim;
        begin
            o   = '0;
            err = 1'b0;
            r   = '0;
            an  = magnitude(an_w);
            ad  = magnitude(ad_w);
            bn  = magnitude(bn_w);
            bd  = magnitude(bd_w);
            case (md)
                MODE_ADD, MODE_SUB:
                begin
                    if (ad == 0 || bd == 0)
                        err = 1'b1;
                    else
                    begin
                        p  = an * bd;
                        q  = bn * ad;
                        ps = an_w[31] ^ bd_w[31];
                        qs = bn_w[31] ^ ad_w[31] ^ (md == MODE_SUB);
                        if (ps == qs)
                        begin
                            s = ps;
                            m = p + q;
                        end
                        else if (p >= q)
                        begin
                            s = ps;
                            m = p - q;
                        end
                        else
                        begin
                            s = qs;
                            m = q - p;
                        end
                        r = reduce_frac(s, m, ad_w[31] ^ bd_w[31], ad * bd);
                    end
                end
                MODE_MUL:
                begin
                    if (ad == 0 || bd == 0)
                        err = 1'b1;
                    else
                        r = reduce_frac(an_w[31] ^ bn_w[31], an * bn,
                                        ad_w[31] ^ bd_w[31], ad * bd);
                end
                MODE_DIV:
                begin
                    if (ad == 0 || bd == 0 || bn == 0)
                        err = 1'b1;
                    else
                        r = reduce_frac(an_w[31] ^ bd_w[31], an * bd,
                                        ad_w[31] ^ bn_w[31], ad * bn);
                end
                MODE_NORM:
                begin
                    if (ad == 0)
                        err = 1'b1;
                    else
                        r = reduce_frac(an_w[31], an, ad_w[31], ad);
                end
                MODE_EQ:
                begin
                    if (ad == 0 || bd == 0)
                        o.st = ST_ZERO;
                    else
                    begin
                        x = reduce_frac(an_w[31], an, ad_w[31], ad);
                        y = reduce_frac(bn_w[31], bn, bd_w[31], bd);
                        o.eq = (x == y);
                    end
                    return o;
                end
                default:
                    err = 1'b1;
            endcase
            if (err)
            begin
                o.st = ST_ZERO;
                return o;
            end
            nlim = r.neg ? 64'h8000_0000 : 64'h7FFF_FFFF;
            if (r.n > nlim || r.d > 64'h7FFF_FFFF)
            begin
                o.st = ST_OVF;
                return o;
            end
            o.num = r.neg ? (32'd0 - r.n[31:0]) : r.n[31:0];
            o.den = r.d[30:0];
            o.st  = ST_OK;
            return o;
        end
    endfunction

    // record every input transfer
    always @(posedge clk)
    begin
        if (rst_n && in_valid && in_ready)
        begin
            if (row_chk)
                expected_q.push_back(row_want);
            else
                expected_q.push_back(predict_fraction(mode, a_num, a_den, b_num, b_den));
        end
    end

    // compare every output transfer
    always @(posedge clk)
    begin
        frac_result_t w;
        if (rst_n && out_valid && out_ready)
        begin
            n_results++;
            if (expected_q.size() == 0)
            begin
                n_errors++;
                $display("%0t: unexpected result num=%h den=%h eq=%b st=%0d", $realtime,
                         res_num, res_den, is_equal, status);
            end
            else
            begin
                w = expected_q.pop_front();
                if (res_num !== w.num)
                begin
                    n_errors++;
                    $display("%0t: res_num expected %h actual %h", $realtime, w.num, res_num);
                end
                if (res_den !== w.den)
                begin
                    n_errors++;
                    $display("%0t: res_den expected %h actual %h", $realtime, w.den, res_den);
                end
                if (is_equal !== w.eq)
                begin
                    n_errors++;
                    $display("%0t: is_equal expected %b actual %b", $realtime, w.eq, is_equal);
                end
                if (status !== w.st)
                begin
                    n_errors++;
                    $display("%0t: status expected %0d actual %0d", $realtime, w.st, status);
                end
            end
        end
    end

    // receiver: stalls in bursts until the calm stretch
    initial
    begin
        int k;
        out_ready = 1'b0;
        @(posedge rst_n);
        forever
        begin
            @(negedge clk);
            if (calm || $urandom_range(0, 5) != 0)
                out_ready <= 1'b1;
            else
            begin
                out_ready <= 1'b0;
                k = $urandom_range(1, 12);
                repeat (k - 1) @(negedge clk);
            end
        end
    end

    // present one item and hold it until the transfer
    task automatic send_fraction(input logic [2:0] md, input logic [31:0] an,
                                 input logic [31:0] ad, input logic [31:0] bn,
                                 input logic [31:0] bd, input logic chk,
                                 input frac_result_t want);
        begin
            @(negedge clk);
            in_valid <= 1'b1;
            mode     <= md;
            a_num    <= an;
            a_den    <= ad;
            b_num    <= bn;
            b_den    <= bd;
            row_chk  <= chk;
            row_want <= want;
            do
                @(posedge clk);
            while (!in_ready);
            n_sent++;
        end
    endtask

    task automatic maybe_gap();
        int k;
        begin
            if (!calm && $urandom_range(0, 4) == 0)
            begin
                k = $urandom_range(1, 12);
                @(negedge clk);
                in_valid <= 1'b0;
                repeat (k - 1) @(negedge clk);
            end
        end
    endtask

    // random operand: small values dominate so reductions are non-trivial
    function automatic logic [31:0] rand_word();
        int sel;
        begin
            sel = $urandom_range(0, 9);
            case (sel)
                0: return $urandom();
                1: return 32'h8000_0000;
                2: return 32'h7FFF_FFFF;
                3: return 32'd0;
                4: return $urandom_range(0, 65535) - 32768;
                default: return $urandom_range(0, 120) - 60;
            endcase
        end
    endfunction

    function automatic logic [31:0] rand_den();
        logic [31:0] v;
        begin
            v = rand_word();
            if (v == 0 && $urandom_range(0, 3) != 0)
                v = 32'd1 + $urandom_range(0, 30);
            return v;
        end
    endfunction

    // main stimulus
    initial
    begin
        logic [2:0] md;
        n_errors  = 0;
        n_results = 0;
        n_sent    = 0;
        calm      = 1'b0;
        rst_n     = 1'b0;
        in_valid  = 1'b0;
        mode      = MODE_ADD;
        a_num     = '0;
        a_den     = '0;
        b_num     = '0;
        b_den     = '0;
        row_chk   = 1'b0;
        row_want  = '0;
        repeat (7) @(posedge clk);
        @(negedge clk);
        rst_n = 1'b1;

        for (int i = 0; i < N_DIR; i++)
        begin
            send_fraction(dir_rows[i].md, dir_rows[i].an, dir_rows[i].ad,
                          dir_rows[i].bn, dir_rows[i].bd, dir_rows[i].chk,
                          dir_rows[i].want);
            maybe_gap();
        end

        for (int i = 0; i < N_RANDOM; i++)
        begin
            if (i == N_RANDOM - N_CALM)
                calm = 1'b1;
            // hold off once until the unit has drained
            if (i == N_RANDOM / 2)
            begin
                @(negedge clk);
                in_valid <= 1'b0;
                while (expected_q.size() != 0)
                    @(negedge clk);
            end
            md = ($urandom_range(0, 19) == 0) ? 3'($urandom_range(6, 7))
                                              : 3'($urandom_range(0, 5));
            send_fraction(md, rand_word(), rand_den(), rand_word(), rand_den(), 1'b0, '0);
            maybe_gap();
        end
        @(negedge clk);
        in_valid <= 1'b0;

        while (expected_q.size() != 0)
            @(negedge clk);
        repeat (600) @(negedge clk);

        $display("Sent %0d fraction items (all six operations, invalid modes, extremes),",
                 n_sent);
        $display("checked %0d results against the predictor, %0d mismatches.",
                 n_results, n_errors);
        if (n_errors == 0 && expected_q.size() == 0)
            $display("rational_arithmetic_unit regression: pass");
        else
            $display("rational_arithmetic_unit regression: fail");
        $finish;
    end

    // watchdog
    initial
    begin
        #50ms;
        $display("rational_arithmetic_unit regression: fail");
        $finish;
    end

endmodule

// ----- rational_arithmetic_unit.f -----
rtl/core/rau_pkg.sv
rtl/core/rau_front.sv
rtl/core/rau_queue.sv
rtl/core/rau_back.sv
rtl/core/rational_arithmetic_unit.sv
sim/rational_arithmetic_unit_tb.sv
